// ===== rtl/hvt_pkg.sv =====
// Shared types and constants for the video H/V timing generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package hvt_pkg;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_WIDE_MODE     = 2'd0,
		REG_TALL_MODE     = 2'd1,
		REG_HINT_INTERVAL = 2'd2,
		REG_BOTTOM_LINE   = 2'd3
	} cfg_idx_t;

	localparam int CFG_DATA_W = 9;

	// Z80 INT line requests
	typedef enum logic [1:0] {
		Z80_NONE     = 2'd0,
		Z80_DEASSERT = 2'd1,
		Z80_ASSERT   = 2'd2
	} z80_act_t;

	// Horizontal landmarks
	localparam logic [7:0] H_EDGE        = 8'h00;
	localparam logic [7:0] H_BLANK_FALL  = 8'h05;
	localparam logic [7:0] H_ADV_WIDE    = 8'ha5;
	localparam logic [7:0] H_ADV_NARROW  = 8'h85;
	localparam logic [7:0] H_RISE_WIDE   = 8'hb3;
	localparam logic [7:0] H_RISE_NARROW = 8'h93;
	localparam logic [7:0] H_JUMP_WIDE   = 8'hb6;
	localparam logic [7:0] H_JUMP_NARROW = 8'h94;
	localparam logic [7:0] H_TO_WIDE     = 8'he4;
	localparam logic [7:0] H_TO_NARROW   = 8'he9;

	// Vertical landmarks
	localparam logic [8:0] V_VBL_TALL  = 9'h0f0;
	localparam logic [8:0] V_VBL_SHORT = 9'h0e0;
	localparam logic [8:0] V_VBL_END   = 9'h1ff;

	// Interrupt delays
	localparam logic [1:0] DELAY_WIDE   = 2'd3;
	localparam logic [1:0] DELAY_NARROW = 2'd2;

	localparam logic [7:0] HINT_RESET   = 8'd255;
	localparam logic [8:0] BOTTOM_RESET = 9'd261;

	typedef struct packed {
		logic       wide_mode;
		logic       tall_mode;
		logic [7:0] hint_interval;
		logic [8:0] bottom_line;
	} cfg_t;

	typedef struct packed {
		logic [7:0] hcount;
		logic [8:0] vcount;
		logic       hblank_flag;
		logic       vblank_flag;
		logic       vblank_changed;
		logic [7:0] hint_count;
		logic [8:0] top_line;
	} state_t;

	typedef struct packed {
		logic [7:0] h_position;
		logic [8:0] v_position;
		logic       hblank_level;
		logic       vblank_level;
		logic       hint_fire;
		logic       vint_fire;
		z80_act_t   z80_int_action;
		logic [1:0] irq_delay;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/video_hv_timing_generator_core.sv =====
// Video H/V timing generator top level over hvt_pkg, hvt_cfg_regs and hvt_step.
// Requests pass the input register, then the result register; low out_ready stalls them.
// Throughput: one request per cycle while out_ready is high; with the output register full,
// a free input stage still takes a new request, and it drains in the cycle the result moves.
// Reset: arst_n clears both pipeline valids, counters and flags at once and loads the
// configuration defaults (32-cell, 28-row, hint interval 255, bottom line 261).
`default_nettype none

module video_hv_timing_generator_core
	import hvt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	// Configuration write port
	input  wire logic                  cfg_we,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,

	// Tick requests
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  line_start,

	// Results
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [7:0]                 h_position,
	output logic [8:0]                 v_position,
	output logic                       hblank_level,
	output logic                       vblank_level,
	output logic                       hint_fire,
	output logic                       vint_fire,
	output logic [1:0]                 z80_int_action,
	output logic [1:0]                 irq_delay
);

	cfg_t    cfg;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	result_t res_s2;

	logic valid_s1;
	logic line_start_s1;
	logic valid_s2;
	logic advance;

	hvt_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stage 1 moves into the result register when that register is empty or drains
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register: hold the request until the tick logic can take it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			line_start_s1 <= line_start;
	end

	hvt_step u_step (
		.cfg        (cfg),
		.cur        (state_q),
		.line_start (line_start_s1),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	// Timing state: advance exactly once per request, as it leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= '0;
		else if (advance)
			state_q <= state_nxt;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= 1'b1;
		else if (out_ready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res_nxt;
	end

	assign out_valid      = valid_s2;
	assign h_position     = res_s2.h_position;
	assign v_position     = res_s2.v_position;
	assign hblank_level   = res_s2.hblank_level;
	assign vblank_level   = res_s2.vblank_level;
	assign hint_fire      = res_s2.hint_fire;
	assign vint_fire      = res_s2.vint_fire;
	assign z80_int_action = res_s2.z80_int_action;
	assign irq_delay      = res_s2.irq_delay;

endmodule

`default_nettype wire

// ===== rtl/hvt_cfg_regs.sv =====
// Configuration register bank for the H/V timing generator.
// Depends on hvt_pkg for the register index codes and cfg_t.
`default_nettype none

module hvt_cfg_regs
	import hvt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wide_mode     <= 1'b0;
			cfg_q.tall_mode     <= 1'b0;
			cfg_q.hint_interval <= HINT_RESET;
			cfg_q.bottom_line   <= BOTTOM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_WIDE_MODE:     cfg_q.wide_mode     <= cfg_data[0];
				REG_TALL_MODE:     cfg_q.tall_mode     <= cfg_data[0];
				REG_HINT_INTERVAL: cfg_q.hint_interval <= cfg_data[7:0];
				REG_BOTTOM_LINE:   cfg_q.bottom_line   <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/hvt_step.sv =====
// Next-state and result logic for one two-pixel tick of the timing generator.
// Purely combinational; depends on hvt_pkg for state_t, cfg_t and result_t.
`default_nettype none

module hvt_step
	import hvt_pkg::*;
(
	input  wire cfg_t   cfg,
	input  wire state_t cur,
	input  wire logic   line_start,
	output state_t      nxt,
	output result_t     res
);

	always_comb begin
		logic [7:0] adv_pos;
		logic [7:0] rise_pos;
		logic [7:0] jump_pos;
		logic [7:0] jump_to;
		logic [1:0] fdelay;
		logic [7:0] hn;
		logic [8:0] vn;
		logic [8:0] vbl_start;
		logic       hint;
		logic       vint;
		z80_act_t   z80;
		logic [1:0] delay;

		adv_pos   = cfg.wide_mode ? H_ADV_WIDE  : H_ADV_NARROW;
		rise_pos  = cfg.wide_mode ? H_RISE_WIDE : H_RISE_NARROW;
		jump_pos  = cfg.wide_mode ? H_JUMP_WIDE : H_JUMP_NARROW;
		jump_to   = cfg.wide_mode ? H_TO_WIDE   : H_TO_NARROW;
		fdelay    = cfg.wide_mode ? DELAY_WIDE  : DELAY_NARROW;
		vbl_start = cfg.tall_mode ? V_VBL_TALL  : V_VBL_SHORT;

		nxt   = cur;
		hint  = 1'b0;
		vint  = 1'b0;
		z80   = Z80_NONE;
		delay = 2'd0;
		vn    = (cur.vcount == cfg.bottom_line) ? cur.top_line : cur.vcount + 9'd1;

		// Restart the line before the increment on request
		hn = (line_start ? 8'd0 : cur.hcount) + 8'd1;

		if (hn == H_EDGE) begin
			z80 = Z80_DEASSERT;
			if (cur.vblank_changed) begin
				nxt.vblank_changed = 1'b0;
				if (cur.vblank_flag) begin
					z80   = Z80_ASSERT;
					vint  = 1'b1;
					delay = fdelay;
				end
			end
		end else if (hn == H_BLANK_FALL) begin
			nxt.hblank_flag = 1'b0;
		end else if (hn == adv_pos) begin
			// Hint down-counter: reload in vblank, fire at zero
			if (cur.vblank_flag) begin
				nxt.hint_count = cfg.hint_interval;
			end else if (cur.hint_count == 8'd0) begin
				nxt.hint_count = cfg.hint_interval;
				hint           = 1'b1;
				delay          = fdelay;
			end else begin
				nxt.hint_count = cur.hint_count - 8'd1;
			end
			nxt.vcount = vn;
			if (vn == vbl_start) begin
				nxt.vblank_changed = cur.vblank_changed | ~cur.vblank_flag;
				nxt.vblank_flag    = 1'b1;
			end
			if (vn == V_VBL_END) begin
				nxt.vblank_changed = cur.vblank_changed | cur.vblank_flag;
				if (cur.vblank_flag)
					nxt.top_line = vn;
				nxt.vblank_flag = 1'b0;
			end
		end else if (hn == rise_pos) begin
			nxt.hblank_flag = 1'b1;
		end else if (hn == jump_pos) begin
			hn = jump_to;
		end

		nxt.hcount = hn;

		res.h_position     = nxt.hcount;
		res.v_position     = nxt.vcount;
		res.hblank_level   = nxt.hblank_flag;
		res.vblank_level   = nxt.vblank_flag;
		res.hint_fire      = hint;
		res.vint_fire      = vint;
		res.z80_int_action = z80;
		res.irq_delay      = delay;
	end

endmodule

`default_nettype wire

// ===== rtl/hvt_checker.sv =====
// Port-level checks for video_hv_timing_generator_core, bound to the top level.
// Depends on hvt_pkg for landmark and code constants.
`default_nettype none

module hvt_checker
	import hvt_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] h_position,
	input wire logic       hint_fire,
	input wire logic       vint_fire,
	input wire logic [1:0] z80_int_action,
	input wire logic [1:0] irq_delay
);

	// Vertical interrupt only at the line edge, paired with a Z80 INT assert
	a_vint_edge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && vint_fire |-> h_position == H_EDGE && z80_int_action == Z80_ASSERT)
		else $error("vint fired away from line edge or without Z80 assert");

	// Horizontal interrupt only at a vertical advance position
	a_hint_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hint_fire |-> h_position == H_ADV_WIDE || h_position == H_ADV_NARROW)
		else $error("hint fired away from vertical advance");

	// Delay is loaded exactly on a fire
	a_delay: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (irq_delay != 2'd0) == (hint_fire || vint_fire))
		else $error("irq_delay does not match interrupt fire");

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(h_position))
		else $error("result changed while stalled");

endmodule

bind video_hv_timing_generator_core hvt_checker u_hvt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.h_position     (h_position),
	.hint_fire      (hint_fire),
	.vint_fire      (vint_fire),
	.z80_int_action (z80_int_action),
	.irq_delay      (irq_delay)
);

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Testbench for video_hv_timing_generator_core: a scoreboard predicts each tick's counters,
// blanking levels and interrupt reports, then checks results in order under handshake stalls.
// Depends on hvt_pkg and the core RTL; needs no files or arguments.

import hvt_pkg::*;

// Beam-position tracker: holds its own copy of the registers and the raster state,
// predicts one result per accepted tick request and checks the results in order.
class raster_tracker;
	bit       wide;
	bit       tall;
	bit [7:0] hint_reload;
	bit [8:0] last_line;

	bit [7:0] hpos;
	bit [8:0] vpos;
	bit       hblank;
	bit       vblank;
	bit       vblank_moved;
	bit [7:0] hint_left;
	bit [8:0] top_line;

	int       lines_stepped;
	int       results_seen;
	int       mismatches;
	result_t  pending_results[$];

	function new();
		wide        = 1'b0;
		tall        = 1'b0;
		hint_reload = HINT_RESET;
		last_line   = BOTTOM_RESET;
	endfunction

	function void set_reg(cfg_idx_t idx, bit [8:0] value);
		case (idx)
			REG_WIDE_MODE:     wide        = value[0];
			REG_TALL_MODE:     tall        = value[0];
			REG_HINT_INTERVAL: hint_reload = value[7:0];
			REG_BOTTOM_LINE:   last_line   = value;
			default: ;
		endcase
	endfunction

	// Latch a vblank edge for the next line edge; the falling edge also latches the top line.
	function void move_vblank(bit level);
		if (vblank != level)
			vblank_moved = 1'b1;
		if (vblank && !level)
			top_line = vpos;
		vblank = level;
	endfunction

	function void note_tick(bit restart);
		result_t  want;
		bit [1:0] delay;
		delay = wide ? DELAY_WIDE : DELAY_NARROW;
		want = '0;
		want.z80_int_action = Z80_NONE;

		if (restart)
			hpos = '0;
		hpos = hpos + 8'd1;

		if (hpos == H_EDGE) begin
			// Every line edge drops Z80 INT; a pending vblank rise raises it instead.
			want.z80_int_action = Z80_DEASSERT;
			if (vblank_moved) begin
				vblank_moved = 1'b0;
				if (vblank) begin
					want.z80_int_action = Z80_ASSERT;
					want.vint_fire      = 1'b1;
					want.irq_delay      = delay;
				end
			end
		end else if (hpos == H_BLANK_FALL) begin
			hblank = 1'b0;
		end else if (hpos == (wide ? H_ADV_WIDE : H_ADV_NARROW)) begin
			lines_stepped++;
			// Reload the hint counter through vblank; fire when it runs out on an active line.
			if (vblank) begin
				hint_left = hint_reload;
			end else if (hint_left == 8'd0) begin
				hint_left      = hint_reload;
				want.hint_fire = 1'b1;
				want.irq_delay = delay;
			end else begin
				hint_left = hint_left - 8'd1;
			end
			vpos = (vpos == last_line) ? top_line : vpos + 9'd1;
			if (vpos == (tall ? V_VBL_TALL : V_VBL_SHORT))
				move_vblank(1'b1);
			if (vpos == V_VBL_END)
				move_vblank(1'b0);
		end else if (hpos == (wide ? H_RISE_WIDE : H_RISE_NARROW)) begin
			hblank = 1'b1;
		end else if (hpos == (wide ? H_JUMP_WIDE : H_JUMP_NARROW)) begin
			hpos = wide ? H_TO_WIDE : H_TO_NARROW;
		end

		want.h_position   = hpos;
		want.v_position   = vpos;
		want.hblank_level = hblank;
		want.vblank_level = vblank;
		pending_results.push_back(want);
	endfunction

	// Print only the first few dozen mismatches; keep counting the rest.
	task report_mismatch(string what);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch at result %0d: %s", results_seen, what);
	endtask

	task check_tick(result_t got);
		result_t want;
		results_seen++;
		if (pending_results.size() == 0) begin
			report_mismatch("result with no tick request pending");
			return;
		end
		want = pending_results.pop_front();
		if (got.h_position !== want.h_position)
			report_mismatch($sformatf("h_position %h, want %h", got.h_position, want.h_position));
		if (got.v_position !== want.v_position)
			report_mismatch($sformatf("v_position %h, want %h", got.v_position, want.v_position));
		if (got.hblank_level !== want.hblank_level)
			report_mismatch($sformatf("hblank_level %b, want %b",
				got.hblank_level, want.hblank_level));
		if (got.vblank_level !== want.vblank_level)
			report_mismatch($sformatf("vblank_level %b, want %b",
				got.vblank_level, want.vblank_level));
		if (got.hint_fire !== want.hint_fire)
			report_mismatch($sformatf("hint_fire %b, want %b", got.hint_fire, want.hint_fire));
		if (got.vint_fire !== want.vint_fire)
			report_mismatch($sformatf("vint_fire %b, want %b", got.vint_fire, want.vint_fire));
		if (got.z80_int_action !== want.z80_int_action)
			report_mismatch($sformatf("z80_int_action %0d, want %0d",
				got.z80_int_action, want.z80_int_action));
		if (got.irq_delay !== want.irq_delay)
			report_mismatch($sformatf("irq_delay %0d, want %0d", got.irq_delay, want.irq_delay));
	endtask
endclass

module tb;
	// Cycles with no handshake on either channel before the run is declared hung.
	localparam int STALL_LIMIT = 2000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [1:0]            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic                  line_start;
	logic                  out_valid;
	logic                  out_ready;
	logic [7:0]            h_position;
	logic [8:0]            v_position;
	logic                  hblank_level;
	logic                  vblank_level;
	logic                  hint_fire;
	logic                  vint_fire;
	logic [1:0]            z80_int_action;
	logic [1:0]            irq_delay;

	int            tx_idle_pct;
	int            rx_idle_pct;
	int            rx_hold;
	int            quiet_cycles;
	result_t       seen;
	raster_tracker sb;

	video_hv_timing_generator_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.line_start     (line_start),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.h_position     (h_position),
		.v_position     (v_position),
		.hblank_level   (hblank_level),
		.vblank_level   (vblank_level),
		.hint_fire      (hint_fire),
		.vint_fire      (vint_fire),
		.z80_int_action (z80_int_action),
		.irq_delay      (irq_delay)
	);

	always #5 clk = ~clk;

	// Result side: stall at random, or hold off entirely while rx_hold counts down.
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold = rx_hold - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Check every accepted result against the oldest prediction.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			seen.h_position     = h_position;
			seen.v_position     = v_position;
			seen.hblank_level   = hblank_level;
			seen.vblank_level   = vblank_level;
			seen.hint_fire      = hint_fire;
			seen.vint_fire      = vint_fire;
			seen.z80_int_action = z80_act_t'(z80_int_action);
			seen.irq_delay      = irq_delay;
			sb.check_tick(seen);
		end
	end

	// Watchdog: quiet_cycles restarts on any handshake; the run gives up when it reaches STALL_LIMIT.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("tb failed");
				$finish;
			end
		end
	end

	// Offer one tick request and hold it until accepted. Idle first at random; the
	// previous call returned right after an edge, so valid is touched once per step.
	task send_tick(input bit restart);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		in_valid   <= 1'b1;
		line_start <= restart;
		do @(posedge clk); while (!in_ready);
		sb.note_tick(restart);
	endtask

	// Drop valid and wait until every predicted result has been taken; one result per
	// request means the core is idle from then on.
	task drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending_results.size() != 0);
	endtask

	// Write one register; lower the enable on the next edge so back-to-back writes stay clean.
	task write_reg(input cfg_idx_t idx, input bit [8:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, value);
		@(posedge clk);
	endtask

	// Random ticks in bursts; between bursts drain and retune one register, often to an
	// extreme. Mode flips mid-line can leave the counter past the new jump point.
	task random_run(input int count);
		int          sent;
		int          burst;
		int unsigned pick;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(120, 15);
			repeat (burst) send_tick($urandom_range(47) == 0);
			sent += burst;
			drain();
			pick = $urandom_range(3);
			case ($urandom_range(3))
				0: write_reg(REG_WIDE_MODE, 9'($urandom_range(1)));
				1: write_reg(REG_TALL_MODE, 9'($urandom_range(1)));
				2: write_reg(REG_HINT_INTERVAL,
					(pick == 0) ? 9'd0 : (pick == 1) ? 9'd255 : 9'($urandom_range(255)));
				default: write_reg(REG_BOTTOM_LINE,
					(pick == 0) ? 9'd0 : (pick == 1) ? 9'd511 : 9'($urandom_range(511)));
			endcase
		end
	endtask

	// Restart the line, run it through the given number of vertical advances, then on past
	// the jump, the line edge and the hblank fall.
	task line_sweep(input int lines);
		int line_end;
		line_end = sb.lines_stepped + lines;
		send_tick(1'b1);
		while (sb.lines_stepped < line_end || sb.hpos != H_BLANK_FALL)
			send_tick(1'b0);
		drain();
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = REG_WIDE_MODE;
		cfg_data     = '0;
		in_valid     = 1'b0;
		line_start   = 1'b0;
		out_ready    = 1'b0;
		rx_hold      = 0;
		quiet_cycles = 0;
		tx_idle_pct  = 22;
		rx_idle_pct  = 66;
		sb = new();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: plain ticks across the hblank fall, a restart, then every register
		// at both extremes with restarts in between.
		repeat (6) send_tick(1'b0);
		send_tick(1'b1);
		repeat (2) send_tick(1'b0);
		drain();
		write_reg(REG_WIDE_MODE, 9'd1);
		write_reg(REG_TALL_MODE, 9'd1);
		write_reg(REG_HINT_INTERVAL, 9'd0);
		write_reg(REG_BOTTOM_LINE, 9'd0);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		repeat (3) send_tick(1'b0);
		drain();
		write_reg(REG_BOTTOM_LINE, 9'h1ff);
		write_reg(REG_HINT_INTERVAL, 9'hff);
		write_reg(REG_WIDE_MODE, 9'd0);
		write_reg(REG_TALL_MODE, 9'd0);
		repeat (4) send_tick(1'b0);
		drain();

		// Sender idles lightly, receiver heavily.
		random_run(80);

		// Swap: sender idles heavily, receiver lightly.
		tx_idle_pct = 66;
		rx_idle_pct = 22;
		random_run(80);

		// No idling. Hold the result side off for a long stretch while requests keep
		// coming, so the pipeline fills and backs up into the input.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold = 60;
		repeat (40) send_tick($urandom_range(15) == 0);
		drain();
		random_run(80);

		// Full line in 32-cell mode with the bottom line at the current line, so the
		// vertical advance wraps to the top line.
		write_reg(REG_WIDE_MODE, 9'd0);
		write_reg(REG_TALL_MODE, 9'd0);
		write_reg(REG_HINT_INTERVAL, 9'd3);
		write_reg(REG_BOTTOM_LINE, sb.vpos);
		line_sweep(1);

		// Full line in 40-cell, 30-row mode with a zero interval: the hint counter reloads
		// to zero, so hint fires on every active line once it runs out.
		write_reg(REG_BOTTOM_LINE, BOTTOM_RESET);
		write_reg(REG_WIDE_MODE, 9'd1);
		write_reg(REG_TALL_MODE, 9'd1);
		write_reg(REG_HINT_INTERVAL, 9'd0);
		line_sweep(1);

		// Let any stray result show up before the verdict.
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule
